>>> rtl/wftc_pkg.sv
// ----------------------------------------------------------------------------
// wftc_pkg: shared types, constants and microcode for the frequency counter
// Holds the payload structs, the control word layout, the flag group and the
// microcode program of the window frequency threshold counter.
// ----------------------------------------------------------------------------
`default_nettype none

package wftc_pkg;

   localparam int NUM_COLOURS = 131072;
   localparam int TREE_DEPTH  = 65536;
   localparam int COLOUR_W    = 17;
   localparam int KVAL_W      = 17;
   localparam int COUNT_W     = 16;
   localparam int SUM_W       = 18;
   localparam int STEP_W      = 5;

   localparam logic [15:0] CAP_RESET = 16'hFFFF;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [3:0] C_NEVER     = 4'd0;
   localparam logic [3:0] C_ALWAYS    = 4'd1;
   localparam logic [3:0] C_NO_REQ    = 4'd2;
   localparam logic [3:0] C_OP_QUERY  = 4'd3;
   localparam logic [3:0] C_OP_NONE   = 4'd4;
   localparam logic [3:0] C_REFUSE    = 4'd5;
   localparam logic [3:0] C_CNT_ZERO  = 4'd6;
   localparam logic [3:0] C_NEW_ZERO  = 4'd7;
   localparam logic [3:0] C_UP_MORE   = 4'd8;
   localparam logic [3:0] C_DOWN_MORE = 4'd9;
   localparam logic [3:0] C_K_OVER    = 4'd10;
   localparam logic [3:0] C_K_ONE     = 4'd11;
   localparam logic [3:0] C_CLR_MORE  = 4'd12;
   localparam logic [3:0] C_OUT_BUSY  = 4'd13;

   localparam logic [2:0] POS_HOLD     = 3'd0;
   localparam logic [2:0] POS_LOAD_CNT = 3'd1;
   localparam logic [2:0] POS_LOAD_NEW = 3'd2;
   localparam logic [2:0] POS_LOAD_CAP = 3'd3;
   localparam logic [2:0] POS_LOAD_KM1 = 3'd4;
   localparam logic [2:0] POS_UP       = 3'd5;
   localparam logic [2:0] POS_DOWN     = 3'd6;

   localparam logic [1:0] ACC_HOLD = 2'd0;
   localparam logic [1:0] ACC_ADD  = 2'd1;
   localparam logic [1:0] ACC_SUB  = 2'd2;

   localparam logic [STEP_W-1:0] STEP_FETCH     = 5'd0;
   localparam logic [STEP_W-1:0] STEP_DISPATCH  = 5'd1;
   localparam logic [STEP_W-1:0] STEP_CNT_READ  = 5'd2;
   localparam logic [STEP_W-1:0] STEP_CNT_CHECK = 5'd3;
   localparam logic [STEP_W-1:0] STEP_DEC_SETUP = 5'd4;
   localparam logic [STEP_W-1:0] STEP_DEC_READ  = 5'd5;
   localparam logic [STEP_W-1:0] STEP_DEC_WRITE = 5'd6;
   localparam logic [STEP_W-1:0] STEP_INC_SETUP = 5'd7;
   localparam logic [STEP_W-1:0] STEP_INC_READ  = 5'd8;
   localparam logic [STEP_W-1:0] STEP_INC_WRITE = 5'd9;
   localparam logic [STEP_W-1:0] STEP_UPD_END   = 5'd10;
   localparam logic [STEP_W-1:0] STEP_Q_SETUP   = 5'd11;
   localparam logic [STEP_W-1:0] STEP_HI_READ   = 5'd12;
   localparam logic [STEP_W-1:0] STEP_HI_SUM    = 5'd13;
   localparam logic [STEP_W-1:0] STEP_LO_SETUP  = 5'd14;
   localparam logic [STEP_W-1:0] STEP_LO_READ   = 5'd15;
   localparam logic [STEP_W-1:0] STEP_LO_SUM    = 5'd16;
   localparam logic [STEP_W-1:0] STEP_DONE      = 5'd17;
   localparam logic [STEP_W-1:0] STEP_RETURN    = 5'd18;
   localparam logic [STEP_W-1:0] STEP_CLEAR     = 5'd19;
   localparam logic [STEP_W-1:0] STEP_CLR_END   = 5'd20;

   typedef struct packed {
      logic [1:0]          op;
      logic [COLOUR_W-1:0] colour;
      logic [KVAL_W-1:0]   min_count;
   } req_type;

   typedef struct packed {
      logic [SUM_W-1:0] colours_at_least;
      logic             error;
   } rsp_type;

   typedef struct packed {
      logic [3:0]        cond;
      logic [STEP_W-1:0] target;
      logic              fetch;
      logic              count_rd;
      logic              count_wr;
      logic              latch_cnt;
      logic              tree_rd;
      logic              tree_wr;
      logic              tree_inc;
      logic [2:0]        pos_op;
      logic [1:0]        acc_op;
      logic              respond;
      logic              clear;
   } ucode_type;

   typedef struct packed {
      logic no_req;
      logic op_query;
      logic op_none;
      logic refuse;
      logic cnt_zero;
      logic new_zero;
      logic up_more;
      logic down_more;
      logic k_over;
      logic k_one;
      logic clr_more;
      logic out_busy;
   } flags_type;

   function automatic ucode_type ucode_word(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '0;
      unique case (step)
         STEP_FETCH: begin
            w.fetch = 1'b1;
            w.cond = C_NO_REQ;
            w.target = STEP_FETCH;
         end
         STEP_DISPATCH: begin
            w.cond = C_OP_QUERY;
            w.target = STEP_Q_SETUP;
         end
         STEP_CNT_READ: begin
            w.count_rd = 1'b1;
            w.cond = C_OP_NONE;
            w.target = STEP_DONE;
         end
         STEP_CNT_CHECK: begin
            w.latch_cnt = 1'b1;
            w.cond = C_REFUSE;
            w.target = STEP_DONE;
         end
         STEP_DEC_SETUP: begin
            w.pos_op = POS_LOAD_CNT;
            w.cond = C_CNT_ZERO;
            w.target = STEP_INC_SETUP;
         end
         STEP_DEC_READ: begin
            w.tree_rd = 1'b1;
         end
         STEP_DEC_WRITE: begin
            w.tree_wr = 1'b1;
            w.pos_op = POS_UP;
            w.cond = C_UP_MORE;
            w.target = STEP_DEC_READ;
         end
         STEP_INC_SETUP: begin
            w.count_wr = 1'b1;
            w.pos_op = POS_LOAD_NEW;
            w.cond = C_NEW_ZERO;
            w.target = STEP_DONE;
         end
         STEP_INC_READ: begin
            w.tree_rd = 1'b1;
         end
         STEP_INC_WRITE: begin
            w.tree_wr = 1'b1;
            w.tree_inc = 1'b1;
            w.pos_op = POS_UP;
            w.cond = C_UP_MORE;
            w.target = STEP_INC_READ;
         end
         STEP_UPD_END: begin
            w.cond = C_ALWAYS;
            w.target = STEP_DONE;
         end
         STEP_Q_SETUP: begin
            w.pos_op = POS_LOAD_CAP;
            w.cond = C_K_OVER;
            w.target = STEP_DONE;
         end
         STEP_HI_READ: begin
            w.tree_rd = 1'b1;
         end
         STEP_HI_SUM: begin
            w.acc_op = ACC_ADD;
            w.pos_op = POS_DOWN;
            w.cond = C_DOWN_MORE;
            w.target = STEP_HI_READ;
         end
         STEP_LO_SETUP: begin
            w.pos_op = POS_LOAD_KM1;
            w.cond = C_K_ONE;
            w.target = STEP_DONE;
         end
         STEP_LO_READ: begin
            w.tree_rd = 1'b1;
         end
         STEP_LO_SUM: begin
            w.acc_op = ACC_SUB;
            w.pos_op = POS_DOWN;
            w.cond = C_DOWN_MORE;
            w.target = STEP_LO_READ;
         end
         STEP_DONE: begin
            w.respond = 1'b1;
            w.cond = C_OUT_BUSY;
            w.target = STEP_DONE;
         end
         STEP_RETURN: begin
            w.cond = C_ALWAYS;
            w.target = STEP_FETCH;
         end
         STEP_CLEAR: begin
            w.clear = 1'b1;
            w.cond = C_CLR_MORE;
            w.target = STEP_CLEAR;
         end
         STEP_CLR_END: begin
            w.cond = C_ALWAYS;
            w.target = STEP_FETCH;
         end
         default: begin
            w.cond = C_ALWAYS;
            w.target = STEP_FETCH;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

>>> rtl/wftc_sequencer.sv
// ----------------------------------------------------------------------------
// wftc_sequencer: microcode step counter
// Holds the step counter, looks up the control word of the current step and
// takes a conditional jump or moves on to the next step.
// ----------------------------------------------------------------------------
`default_nettype none

module wftc_sequencer
   import wftc_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire flags_type flags,
   output ucode_type      ctrl
);

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              taken;

   assign ctrl = ucode_word(step_ff);

   always_comb begin
      unique case (ctrl.cond)
         C_NEVER:     taken = 1'b0;
         C_ALWAYS:    taken = 1'b1;
         C_NO_REQ:    taken = flags.no_req;
         C_OP_QUERY:  taken = flags.op_query;
         C_OP_NONE:   taken = flags.op_none;
         C_REFUSE:    taken = flags.refuse;
         C_CNT_ZERO:  taken = flags.cnt_zero;
         C_NEW_ZERO:  taken = flags.new_zero;
         C_UP_MORE:   taken = flags.up_more;
         C_DOWN_MORE: taken = flags.down_more;
         C_K_OVER:    taken = flags.k_over;
         C_K_ONE:     taken = flags.k_one;
         C_CLR_MORE:  taken = flags.clr_more;
         C_OUT_BUSY:  taken = flags.out_busy;
         default:     taken = 1'b0;
      endcase
      step_in = taken ? ctrl.target : step_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_CLEAR;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/wftc_datapath.sv
// ----------------------------------------------------------------------------
// wftc_datapath: count store, Fenwick tree store and arithmetic
// Holds the per-colour counts, the tree of colours per exact count, the
// position and sum registers, the capacity register and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wftc_datapath
   import wftc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ucode_type   ctrl,
   input  wire logic        req_valid,
   input  wire req_type     req_data,
   input  wire logic        rsp_stall,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   output flags_type        flags
);

   logic [COUNT_W-1:0]  count_mem [NUM_COLOURS];
   logic [SUM_W-1:0]    tree_mem  [TREE_DEPTH];

   logic [15:0]         cap_ff;
   logic [COLOUR_W-1:0] clr_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;
   logic [1:0]          op_ff;
   logic [COLOUR_W-1:0] colour_ff;
   logic [KVAL_W-1:0]   k_ff;
   logic [COUNT_W-1:0]  cnt_ff;
   logic [COUNT_W-1:0]  cnt_rdata_ff;
   logic [SUM_W-1:0]    tree_rdata_ff;
   logic [COUNT_W-1:0]  pos_ff;
   logic [COUNT_W-1:0]  pos_in;
   logic [SUM_W-1:0]    acc_ff;
   logic                err_ff;

   logic [KVAL_W-1:0]   k_eff;
   logic [COUNT_W-1:0]  new_cnt;
   logic [COUNT_W-1:0]  low_bit;
   logic [COUNT_W:0]    pos_up;
   logic [COUNT_W-1:0]  pos_down;
   logic                refuse;
   logic                accept;
   logic                out_busy;

   logic                cnt_we;
   logic [COLOUR_W-1:0] cnt_waddr;
   logic [COUNT_W-1:0]  cnt_wdata;
   logic                tree_we;
   logic [COUNT_W-1:0]  tree_waddr;
   logic [SUM_W-1:0]    tree_wdata;

   always_comb begin
      accept   = ctrl.fetch & req_valid;
      out_busy = rsp_valid_ff & rsp_stall;
      k_eff    = (k_ff == '0) ? KVAL_W'(1) : k_ff;
      new_cnt  = (op_ff == OP_ADD) ? cnt_ff + 1'b1 : cnt_ff - 1'b1;
      low_bit  = pos_ff & (~pos_ff + 1'b1);
      pos_up   = {1'b0, pos_ff} + {1'b0, low_bit};
      pos_down = pos_ff - low_bit;
      refuse   = ((op_ff == OP_ADD) && (cnt_rdata_ff >= cap_ff)) ||
                 ((op_ff == OP_REMOVE) && (cnt_rdata_ff == '0));

      flags.no_req    = ~req_valid;
      flags.op_query  = (op_ff == OP_QUERY);
      flags.op_none   = (op_ff == OP_NONE);
      flags.refuse    = refuse;
      flags.cnt_zero  = (cnt_ff == '0);
      flags.new_zero  = (new_cnt == '0);
      flags.up_more   = ~pos_up[COUNT_W];
      flags.down_more = (pos_down != '0);
      flags.k_over    = (k_eff > {1'b0, cap_ff});
      flags.k_one     = (k_eff == KVAL_W'(1));
      flags.clr_more  = (clr_ff != '1);
      flags.out_busy  = out_busy;

      case (ctrl.pos_op)
         POS_LOAD_CNT: pos_in = cnt_ff;
         POS_LOAD_NEW: pos_in = new_cnt;
         POS_LOAD_CAP: pos_in = cap_ff;
         POS_LOAD_KM1: pos_in = COUNT_W'(k_eff - 1'b1);
         POS_UP:       pos_in = pos_up[COUNT_W-1:0];
         POS_DOWN:     pos_in = pos_down;
         default:      pos_in = pos_ff;
      endcase

      cnt_we     = ctrl.clear | ctrl.count_wr;
      cnt_waddr  = ctrl.clear ? clr_ff : colour_ff;
      cnt_wdata  = ctrl.clear ? '0 : new_cnt;
      tree_we    = ctrl.clear | ctrl.tree_wr;
      tree_waddr = ctrl.clear ? clr_ff[COUNT_W-1:0] : pos_ff;
      if (ctrl.clear) begin
         tree_wdata = '0;
      end else if (ctrl.tree_inc) begin
         tree_wdata = tree_rdata_ff + 1'b1;
      end else begin
         tree_wdata = tree_rdata_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         count_mem[cnt_waddr] <= cnt_wdata;
      end
      if (ctrl.count_rd) begin
         cnt_rdata_ff <= count_mem[colour_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (tree_we) begin
         tree_mem[tree_waddr] <= tree_wdata;
      end
      if (ctrl.tree_rd) begin
         tree_rdata_ff <= tree_mem[pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (ctrl.clear) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (ctrl.respond && !out_busy) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_data.op;
         colour_ff <= req_data.colour;
         k_ff      <= req_data.min_count;
         acc_ff    <= '0;
         err_ff    <= 1'b0;
      end else begin
         case (ctrl.acc_op)
            ACC_ADD: acc_ff <= acc_ff + tree_rdata_ff;
            ACC_SUB: acc_ff <= acc_ff - tree_rdata_ff;
            default: acc_ff <= acc_ff;
         endcase
         if (ctrl.latch_cnt) begin
            err_ff <= refuse;
         end
      end
      if (ctrl.latch_cnt) begin
         cnt_ff <= cnt_rdata_ff;
      end
      pos_ff <= pos_in;
      if (ctrl.respond && !out_busy) begin
         rsp_ff.colours_at_least <= acc_ff;
         rsp_ff.error            <= err_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

>>> rtl/window_frequency_threshold_counter.sv
// ----------------------------------------------------------------------------
// window_frequency_threshold_counter: distinct colours at or above a count
// Each request adds one occurrence of a colour, removes one, asks how many
// distinct colours occur at least min_count times, up to the window capacity, or does nothing.
// Request and response channels use valid and stall; a transfer happens at a
// clock edge with valid high and stall low. Every request gives one response.
// The capacity register is written through csr_wr_en and csr_wr_data.
// One request is processed at a time by a microcoded sequencer. The tree store
// has one read and one write per cycle; each tree node touched takes a read
// step and then a write or accumulate step. Refused updates finish early.
// After reset, a clearing pass zeroes both stores one entry per cycle while
// req_stall stays high; capacity writes are still taken. A finished response
// waits in an output register while rsp_stall is high, and the next request
// is already accepted and processed behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module window_frequency_threshold_counter
   import wftc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   ucode_type ctrl;
   flags_type flags;

   assign req_stall = ~ctrl.fetch;

   wftc_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   wftc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .flags       (flags)
   );

endmodule

`default_nettype wire

>>> bench/colour_count_checker.sv
// ----------------------------------------------------------------------------
// colour_count_checker: response predictor and scoreboard
// Watches the request, response and capacity ports of the frequency counter.
// It keeps its own occurrence count per colour and its own copy of the window
// capacity. For every request transfer it works out the response, and it
// compares each response transfer with the oldest outstanding one.
// ----------------------------------------------------------------------------
module colour_count_checker
   import wftc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output int          fail_count,
   output int          answers_seen,
   output int          pending
);

   int unsigned colour_tally [int unsigned];
   logic [15:0] capacity;
   rsp_type     expected_answers [$];
   rsp_type     oldest;

   initial begin
      fail_count = 0;
      answers_seen = 0;
      pending = 0;
      capacity = CAP_RESET;
   end

   function automatic rsp_type tally_response(input req_type item);
      rsp_type     answer;
      int unsigned held;
      int unsigned threshold;
      int unsigned hits;
      answer = '0;
      held = 0;
      hits = 0;
      if (colour_tally.exists(item.colour)) begin
         held = colour_tally[item.colour];
      end
      case (item.op)
         OP_ADD: begin
            if (held >= capacity) begin
               answer.error = 1'b1;
            end else begin
               colour_tally[item.colour] = held + 1;
            end
         end
         OP_REMOVE: begin
            if (held == 0) begin
               answer.error = 1'b1;
            end else if (held == 1) begin
               colour_tally.delete(item.colour);
            end else begin
               colour_tally[item.colour] = held - 1;
            end
         end
         OP_QUERY: begin
            threshold = (item.min_count == 0) ? 1 : item.min_count;
            if (threshold <= capacity) begin
               foreach (colour_tally[c]) begin
                  if (colour_tally[c] >= threshold && colour_tally[c] <= capacity) begin
                     hits++;
                  end
               end
            end
            answer.colours_at_least = hits[SUM_W-1:0];
         end
         default: begin
         end
      endcase
      return answer;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         colour_tally.delete();
         expected_answers.delete();
         capacity = CAP_RESET;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            answers_seen++;
            if (expected_answers.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response, colours_at_least %0d, error %0b",
                        $time, rsp_data.colours_at_least, rsp_data.error);
            end else begin
               oldest = expected_answers.pop_front();
               if (rsp_data.colours_at_least !== oldest.colours_at_least) begin
                  fail_count++;
                  $display("%0t: colours_at_least expected %0d, got %0d",
                           $time, oldest.colours_at_least, rsp_data.colours_at_least);
               end
               if (rsp_data.error !== oldest.error) begin
                  fail_count++;
                  $display("%0t: error expected %0b, got %0b",
                           $time, oldest.error, rsp_data.error);
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_answers.insert(expected_answers.size(), tally_response(req_data));
         end
         if (csr_wr_en) begin
            capacity = csr_wr_data;
         end
      end
      pending = expected_answers.size();
   end

endmodule

>>> bench/window_frequency_threshold_counter_tb.sv
// ----------------------------------------------------------------------------
// window_frequency_threshold_counter_tb: top level of the counter testbench
// Drives add, remove and query requests into the frequency counter under
// several window capacities, starting with a directed set of corner cases and
// going on with random traffic over a small colour pool. Both channels idle at
// random, and the receiver once holds off long enough to back up the input.
// A separate checker predicts and compares every response.
// ----------------------------------------------------------------------------
module window_frequency_threshold_counter_tb;
   import wftc_pkg::*;

   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 80;
   localparam int PHASE_ITEMS = 254;
   localparam int PHASES      = 6;
   localparam int K_MAX       = 2 ** KVAL_W - 1;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   int          fail_count;
   int          answers_seen;
   int          pending;
   int          items_sent = 0;
   int          cycle_count = 0;
   int          capacity_writes = 0;
   int          sender_idle_pct = 18;
   int          receiver_idle_pct = 45;
   int          pool_span = 16;
   bit          hold_pending = 1'b0;
   logic [15:0] capacity = CAP_RESET;
   int unsigned colour_pool [16];
   logic [15:0] phase_caps [PHASES];

   window_frequency_threshold_counter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   colour_count_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .fail_count   (fail_count),
      .answers_seen (answers_seen),
      .pending      (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped by the cycle limit with %0d of %0d responses in.",
                  answers_seen, items_sent);
         $display("TEST FAILED");
         $finish;
      end
   end

   // The long hold-off is counted here so the sender keeps offering requests.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
         end
      end
   end

   function automatic req_type make_req(input logic [1:0] op, input int unsigned colour,
                                        input int unsigned k);
      req_type item;
      item.op = op;
      item.colour = colour[COLOUR_W-1:0];
      item.min_count = k[KVAL_W-1:0];
      return item;
   endfunction

   function automatic req_type random_item();
      req_type     item;
      int unsigned pick;
      int          near_cap;
      pick = $urandom_range(99);
      item.op = (pick < 45) ? OP_ADD : (pick < 70) ? OP_REMOVE :
                (pick < 97) ? OP_QUERY : OP_NONE;
      if ($urandom_range(99) < 85) begin
         item.colour = COLOUR_W'(colour_pool[$urandom_range(pool_span - 1)]);
      end else begin
         item.colour = COLOUR_W'($urandom_range(NUM_COLOURS - 1));
      end
      pick = $urandom_range(99);
      near_cap = int'(capacity) + int'($urandom_range(4)) - 2;
      if (pick < 65) begin
         item.min_count = KVAL_W'($urandom_range(40));
      end else if (pick < 85) begin
         item.min_count = near_cap[KVAL_W-1:0];
      end else begin
         item.min_count = KVAL_W'($urandom_range(K_MAX));
      end
      return item;
   endfunction

   task automatic send_item(input req_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (answers_seen < items_sent) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [15:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      capacity = value;
      capacity_writes++;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      foreach (colour_pool[i]) colour_pool[i] = $urandom_range(NUM_COLOURS - 1);
      phase_caps = '{16'hFFFF, 16'd5, 16'd1, 16'd0, 16'd2, 16'hFFFF};
      phase_caps[3] = 16'($urandom_range(1000, 3));
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // A small capacity lets one colour reach the limit quickly.
      write_capacity(16'd3);
      send_item(make_req(OP_QUERY, 0, 0));
      send_item(make_req(OP_REMOVE, 5, 1));
      send_item(make_req(OP_ADD, 0, 1));
      repeat (4) send_item(make_req(OP_ADD, NUM_COLOURS - 1, 1));
      send_item(make_req(OP_QUERY, 0, 1));
      send_item(make_req(OP_QUERY, 0, 3));
      send_item(make_req(OP_QUERY, 0, 4));
      send_item(make_req(OP_QUERY, 0, K_MAX));
      send_item(make_req(OP_NONE, NUM_COLOURS - 1, K_MAX));
      send_item(make_req(OP_REMOVE, 0, 1));
      send_item(make_req(OP_REMOVE, 0, 1));

      // Lowering the capacity leaves a colour counted above it.
      write_capacity(16'd1);
      send_item(make_req(OP_QUERY, 0, 1));
      send_item(make_req(OP_ADD, NUM_COLOURS - 1, 1));
      send_item(make_req(OP_REMOVE, NUM_COLOURS - 1, 1));
      send_item(make_req(OP_ADD, 'h0AAAA, 1));
      send_item(make_req(OP_QUERY, 0, 1));

      write_capacity(16'd0);
      send_item(make_req(OP_ADD, 7, 1));
      send_item(make_req(OP_QUERY, 0, 0));
      send_item(make_req(OP_REMOVE, 'h0AAAA, 1));

      write_capacity(16'hFFFF);
      send_item(make_req(OP_QUERY, 0, 1));
      send_item(make_req(OP_QUERY, 0, 65535));
      send_item(make_req(OP_QUERY, 0, TREE_DEPTH));

      for (int phase = 0; phase < PHASES; phase++) begin
         write_capacity(phase_caps[phase]);
         sender_idle_pct = (phase < 2) ? 18 : (phase < 4) ? 45 : 0;
         receiver_idle_pct = (phase < 2) ? 45 : (phase < 4) ? 18 : 0;
         pool_span = (phase_caps[phase] > 100) ? 4 : 16;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 1 && n == PHASE_ITEMS / 2) begin
               hold_pending = 1'b1;
            end
            send_item(random_item());
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d add, remove and query requests under %0d capacity writes,",
               items_sent, capacity_writes);
      $display("with one %0d-cycle response hold-off; %0d responses checked, %0d missing.",
               HOLD_CYCLES, answers_seen, pending);
      if (fail_count == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
